@@ rtl/dqp_pkg.sv @@
`timescale 1ns / 1ps

package dqp_pkg;

  localparam int HEADER_BYTES = 12;
  localparam int TYPECLASS_BYTES = 4;
  localparam int DEFAULT_MAX_NAME_LENGTH = 255;
  localparam logic [7:0] DOT_CHAR = 8'h2E;

  localparam logic [1:0] KIND_CHAR = 2'd0;
  localparam logic [1:0] KIND_SUMMARY = 2'd1;
  localparam logic [1:0] KIND_ERROR = 2'd2;

  localparam logic [2:0] ERR_NONE = 3'd0;
  localparam logic [2:0] ERR_TOO_SHORT = 3'd1;
  localparam logic [2:0] ERR_NOT_QUERY = 3'd2;
  localparam logic [2:0] ERR_TOO_MANY_QUESTIONS = 3'd3;
  localparam logic [2:0] ERR_NAME_TOO_LONG = 3'd4;

  typedef enum logic [3:0] {
    PH_HEADER    = 4'b0001,
    PH_NAME      = 4'b0010,
    PH_TYPECLASS = 4'b0100,
    PH_DRAIN     = 4'b1000
  } phase_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  name_char;
    logic [15:0] transaction_id;
    logic [15:0] flags_word;
    logic [3:0]  opcode;
    logic        question_count;
    logic [15:0] answer_count;
    logic [15:0] authority_count;
    logic [15:0] additional_count;
    logic [15:0] query_type;
    logic [15:0] query_class;
    logic [2:0]  error_code;
  } result_t;

endpackage

@@ rtl/dqp_if.sv @@
`timescale 1ns / 1ps

interface dqp_msg_if;
  logic       valid;
  logic       ready;
  logic [7:0] msg_byte;
  logic       msg_last;

  modport source (output valid, output msg_byte, output msg_last, input ready);
  modport sink (input valid, input msg_byte, input msg_last, output ready);
endinterface

interface dqp_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [7:0]  name_char;
  logic [15:0] transaction_id;
  logic [15:0] flags_word;
  logic [3:0]  opcode;
  logic        question_count;
  logic [15:0] answer_count;
  logic [15:0] authority_count;
  logic [15:0] additional_count;
  logic [15:0] query_type;
  logic [15:0] query_class;
  logic [2:0]  error_code;

  modport source (
    output valid, output kind, output name_char, output transaction_id,
    output flags_word, output opcode, output question_count, output answer_count,
    output authority_count, output additional_count, output query_type,
    output query_class, output error_code, input ready
  );
  modport sink (
    input valid, input kind, input name_char, input transaction_id,
    input flags_word, input opcode, input question_count, input answer_count,
    input authority_count, input additional_count, input query_type,
    input query_class, input error_code, output ready
  );
endinterface

@@ rtl/dns_query_parser.sv @@
// A result appears in the output register in the cycle after the byte that causes it.
// Throughput: one message byte per cycle; the single output register is refilled in the
// cycle it is taken, so the input stalls only while a result waits to be taken.
// Reset (rst, synchronous, active high) returns the parser to the start of the header
// and empties the output register.
`timescale 1ns / 1ps

module dns_query_parser #(
  parameter int MAX_NAME_LENGTH = dqp_pkg::DEFAULT_MAX_NAME_LENGTH
) (
  input logic         clk,
  input logic         rst,
  dqp_msg_if.sink     msg,
  dqp_result_if.source result
);

  localparam logic [8:0] NAME_LIMIT = 9'(MAX_NAME_LENGTH);

  dqp_pkg::phase_t phase, phase_next;
  logic [3:0]  byte_index, byte_index_next;
  logic [7:0]  label_remaining, label_remaining_next;
  logic        label_seen, label_seen_next;
  logic [8:0]  name_length, name_length_next;
  logic [15:0] id_reg, id_reg_next;
  logic [15:0] flags_reg, flags_reg_next;
  logic [15:0] qd_reg, qd_reg_next;
  logic [15:0] an_reg, an_reg_next;
  logic [15:0] ns_reg, ns_reg_next;
  logic [15:0] ar_reg, ar_reg_next;
  logic [31:0] type_class_reg, type_class_reg_next;

  dqp_pkg::result_t res, res_next;
  logic res_valid;
  logic res_emit;
  logic in_fire;
  logic name_emit;
  logic [7:0] b;
  logic last;

  assign msg.ready = !res_valid || result.ready;
  assign in_fire = msg.valid && msg.ready;
  assign b = msg.msg_byte;
  assign last = msg.msg_last;

  always_comb begin
    phase_next = phase;
    byte_index_next = byte_index;
    label_remaining_next = label_remaining;
    label_seen_next = label_seen;
    name_length_next = name_length;
    id_reg_next = id_reg;
    flags_reg_next = flags_reg;
    qd_reg_next = qd_reg;
    an_reg_next = an_reg;
    ns_reg_next = ns_reg;
    ar_reg_next = ar_reg;
    type_class_reg_next = type_class_reg;
    res_emit = 1'b0;
    res_next = '0;
    name_emit = 1'b0;

    if (in_fire) begin
      unique case (phase)
        dqp_pkg::PH_HEADER: begin
          unique case (byte_index[3:1])
            3'd0: id_reg_next = {id_reg[7:0], b};
            3'd1: flags_reg_next = {flags_reg[7:0], b};
            3'd2: qd_reg_next = {qd_reg[7:0], b};
            3'd3: an_reg_next = {an_reg[7:0], b};
            3'd4: ns_reg_next = {ns_reg[7:0], b};
            default: ar_reg_next = {ar_reg[7:0], b};
          endcase
          if (byte_index < 4'(dqp_pkg::HEADER_BYTES - 1)) begin
            byte_index_next = byte_index + 4'd1;
            if (last) begin
              res_emit = 1'b1;
              res_next.kind = dqp_pkg::KIND_ERROR;
              res_next.error_code = dqp_pkg::ERR_TOO_SHORT;
            end
          end else if (flags_reg[15]) begin
            res_emit = 1'b1;
            res_next.kind = dqp_pkg::KIND_ERROR;
            res_next.error_code = dqp_pkg::ERR_NOT_QUERY;
          end else if (qd_reg > 16'd1) begin
            res_emit = 1'b1;
            res_next.kind = dqp_pkg::KIND_ERROR;
            res_next.error_code = dqp_pkg::ERR_TOO_MANY_QUESTIONS;
          end else if (qd_reg == 16'd0) begin
            res_emit = 1'b1;
            res_next.kind = dqp_pkg::KIND_SUMMARY;
          end else if (last) begin
            res_emit = 1'b1;
            res_next.kind = dqp_pkg::KIND_ERROR;
            res_next.error_code = dqp_pkg::ERR_TOO_SHORT;
          end else begin
            phase_next = dqp_pkg::PH_NAME;
            byte_index_next = '0;
            label_remaining_next = '0;
            label_seen_next = 1'b0;
            name_length_next = '0;
            type_class_reg_next = '0;
          end
        end
        dqp_pkg::PH_NAME: begin
          if (label_remaining == 8'd0 && b == 8'd0) begin
            if (last) begin
              res_emit = 1'b1;
              res_next.kind = dqp_pkg::KIND_ERROR;
              res_next.error_code = dqp_pkg::ERR_TOO_SHORT;
            end else begin
              phase_next = dqp_pkg::PH_TYPECLASS;
              byte_index_next = '0;
            end
          end else begin
            name_emit = (label_remaining != 8'd0) || label_seen;
            if (name_emit && name_length >= NAME_LIMIT) begin
              res_emit = 1'b1;
              res_next.kind = dqp_pkg::KIND_ERROR;
              res_next.error_code = dqp_pkg::ERR_NAME_TOO_LONG;
            end else if (last) begin
              res_emit = 1'b1;
              res_next.kind = dqp_pkg::KIND_ERROR;
              res_next.error_code = dqp_pkg::ERR_TOO_SHORT;
            end else if (label_remaining != 8'd0) begin
              label_remaining_next = label_remaining - 8'd1;
              res_emit = 1'b1;
              res_next.kind = dqp_pkg::KIND_CHAR;
              res_next.name_char = b;
              name_length_next = name_length + 9'd1;
            end else begin
              label_remaining_next = b;
              if (name_emit) begin
                res_emit = 1'b1;
                res_next.kind = dqp_pkg::KIND_CHAR;
                res_next.name_char = dqp_pkg::DOT_CHAR;
                name_length_next = name_length + 9'd1;
              end else begin
                label_seen_next = 1'b1;
              end
            end
          end
        end
        dqp_pkg::PH_TYPECLASS: begin
          type_class_reg_next = {type_class_reg[23:0], b};
          byte_index_next = byte_index + 4'd1;
          if (byte_index_next >= 4'(dqp_pkg::TYPECLASS_BYTES)) begin
            res_emit = 1'b1;
            res_next.kind = dqp_pkg::KIND_SUMMARY;
            res_next.query_type = type_class_reg_next[31:16];
            res_next.query_class = type_class_reg_next[15:0];
          end else if (last) begin
            res_emit = 1'b1;
            res_next.kind = dqp_pkg::KIND_ERROR;
            res_next.error_code = dqp_pkg::ERR_TOO_SHORT;
          end
        end
        dqp_pkg::PH_DRAIN: begin
          if (last) begin
            phase_next = dqp_pkg::PH_HEADER;
            byte_index_next = '0;
            label_remaining_next = '0;
            label_seen_next = 1'b0;
            name_length_next = '0;
          end
        end
        default: begin
          phase_next = dqp_pkg::PH_HEADER;
        end
      endcase

      if (res_next.kind == dqp_pkg::KIND_SUMMARY) begin
        res_next.transaction_id = id_reg_next;
        res_next.flags_word = flags_reg_next;
        res_next.opcode = flags_reg_next[14:11];
        res_next.question_count = qd_reg_next[0];
        res_next.answer_count = an_reg_next;
        res_next.authority_count = ns_reg_next;
        res_next.additional_count = ar_reg_next;
      end

      // An error or a summary ends the message; the rest of it is skipped.
      if (res_emit && res_next.kind != dqp_pkg::KIND_CHAR) begin
        if (last) begin
          phase_next = dqp_pkg::PH_HEADER;
          byte_index_next = '0;
          label_remaining_next = '0;
          label_seen_next = 1'b0;
          name_length_next = '0;
        end else begin
          phase_next = dqp_pkg::PH_DRAIN;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= dqp_pkg::PH_HEADER;
      byte_index <= '0;
      label_remaining <= '0;
      label_seen <= 1'b0;
      name_length <= '0;
      id_reg <= '0;
      flags_reg <= '0;
      qd_reg <= '0;
      an_reg <= '0;
      ns_reg <= '0;
      ar_reg <= '0;
      type_class_reg <= '0;
      res_valid <= 1'b0;
    end else begin
      phase <= phase_next;
      byte_index <= byte_index_next;
      label_remaining <= label_remaining_next;
      label_seen <= label_seen_next;
      name_length <= name_length_next;
      id_reg <= id_reg_next;
      flags_reg <= flags_reg_next;
      qd_reg <= qd_reg_next;
      an_reg <= an_reg_next;
      ns_reg <= ns_reg_next;
      ar_reg <= ar_reg_next;
      type_class_reg <= type_class_reg_next;
      if (res_emit) begin
        res_valid <= 1'b1;
      end else if (result.ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_emit) begin
      res <= res_next;
    end
  end

  assign result.valid = res_valid;
  assign result.kind = res.kind;
  assign result.name_char = res.name_char;
  assign result.transaction_id = res.transaction_id;
  assign result.flags_word = res.flags_word;
  assign result.opcode = res.opcode;
  assign result.question_count = res.question_count;
  assign result.answer_count = res.answer_count;
  assign result.authority_count = res.authority_count;
  assign result.additional_count = res.additional_count;
  assign result.query_type = res.query_type;
  assign result.query_class = res.query_class;
  assign result.error_code = res.error_code;

  a_drain_silent: assert property (@(posedge clk) disable iff (rst)
    in_fire && phase == dqp_pkg::PH_DRAIN |-> !res_emit)
    else $error("Result produced while skipping the rest of a message.");

  a_last_restarts: assert property (@(posedge clk) disable iff (rst)
    in_fire && msg.msg_last |=> phase == dqp_pkg::PH_HEADER && byte_index == 4'd0)
    else $error("Parser did not return to the header after the final byte.");

  a_name_limit: assert property (@(posedge clk) disable iff (rst)
    res_emit && res_next.kind == dqp_pkg::KIND_CHAR |-> name_length < NAME_LIMIT)
    else $error("Name character emitted beyond the length limit.");

  a_summary_place: assert property (@(posedge clk) disable iff (rst)
    res_emit && res_next.kind == dqp_pkg::KIND_SUMMARY |->
      (phase == dqp_pkg::PH_HEADER && byte_index == 4'(dqp_pkg::HEADER_BYTES - 1)) ||
      (phase == dqp_pkg::PH_TYPECLASS &&
       byte_index == 4'(dqp_pkg::TYPECLASS_BYTES - 1)))
    else $error("Summary produced at an unexpected byte.");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    res_valid && !result.ready |-> !in_fire)
    else $error("A transaction was accepted while a result was waiting.");

endmodule
